// ----- hw/rtl/fpn_pkg.sv -----
// Package for the five-point pulse normalizer.
// Holds the shared widths, reset setpoints, register indexes and the item descriptor.
// Depends on nothing; every module of the block imports it.
package fpn_pkg;

  localparam int PT_W       = 16;
  localparam int OUT_W      = 17;
  localparam int FRAC_W     = 14;
  localparam int QUOT_W     = FRAC_W + 1;
  localparam int NUM_POINTS = 5;
  localparam int NUM_SEGS   = NUM_POINTS - 1;
  localparam int SEG_W      = $clog2(NUM_SEGS);
  localparam int CFG_IDX_W  = 3;

  localparam logic [OUT_W-1:0] NORM_FULL = OUT_W'(1) << (OUT_W - 1);

  localparam logic [PT_W-1:0] POINT_RESET [NUM_POINTS] = '{
    16'd1000, 16'd1250, 16'd1500, 16'd1750, 16'd2000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_0 = 3'd0,
    REG_POINT_1 = 3'd1,
    REG_POINT_2 = 3'd2,
    REG_POINT_3 = 3'd3,
    REG_POINT_4 = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_ZERO = 2'd0,
    OP_FULL = 2'd1,
    OP_BASE = 2'd2,
    OP_DIV  = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SEG_W-1:0] seg;
    logic [PT_W-1:0]  num;
    logic [PT_W-1:0]  den;
  } desc_t;

endpackage

// ----- hw/rtl/fpn_front.sv -----
// Front end of the pulse normalizer: setpoint registers and segment classification.
// Turns each accepted pulse into a registered descriptor. Depends on fpn_pkg.
module fpn_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [fpn_pkg::PT_W-1:0]      pulse_width,
  input  logic                          cfg_write,
  input  logic [fpn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpn_pkg::PT_W-1:0]      cfg_data,
  output logic                          desc_valid,
  output fpn_pkg::desc_t                desc
);
  import fpn_pkg::*;

  logic [PT_W-1:0] pt [NUM_POINTS];
  desc_t           desc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        pt[i] <= POINT_RESET[i];
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POINT_0: pt[0] <= cfg_data;
        REG_POINT_1: pt[1] <= cfg_data;
        REG_POINT_2: pt[2] <= cfg_data;
        REG_POINT_3: pt[3] <= cfg_data;
        REG_POINT_4: pt[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The lowest segment whose test holds wins, so the inner loop runs from the top down.
  always_comb begin
    desc_next = '{op: OP_ZERO, seg: '0, num: '0, den: '0};
    if (pt[NUM_POINTS-1] > pt[0]) begin
      if (pulse_width < pt[0]) begin
        desc_next.op = OP_ZERO;
      end else if (pulse_width > pt[NUM_POINTS-1]) begin
        desc_next.op = OP_FULL;
      end else if (pulse_width <= pt[1]) begin
        desc_next = '{op: OP_DIV, seg: '0, num: pulse_width - pt[0], den: pt[1] - pt[0]};
      end else begin
        for (int k = NUM_SEGS - 1; k >= 1; k--) begin
          if (pulse_width > pt[k] && pulse_width <= pt[k+1]) begin
            desc_next = '{op: OP_DIV, seg: SEG_W'(k), num: pulse_width - pt[k],
                          den: pt[k+1] - pt[k]};
          end
        end
      end
    end else if (pt[0] > pt[NUM_POINTS-1]) begin
      if (pulse_width > pt[0]) begin
        desc_next.op = OP_ZERO;
      end else if (pulse_width < pt[NUM_POINTS-1]) begin
        desc_next.op = OP_FULL;
      end else if (pulse_width >= pt[1]) begin
        desc_next = '{op: OP_DIV, seg: '0, num: pt[0] - pulse_width, den: pt[0] - pt[1]};
      end else begin
        for (int k = NUM_SEGS - 1; k >= 1; k--) begin
          if (pulse_width < pt[k] && pulse_width >= pt[k+1]) begin
            desc_next = '{op: OP_DIV, seg: SEG_W'(k), num: pt[k] - pulse_width,
                          den: pt[k] - pt[k+1]};
          end
        end
      end
    end
    // A zero-length segment yields its base value without a division.
    if (desc_next.op == OP_DIV && desc_next.den == '0) begin
      desc_next.op = OP_BASE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else begin
      desc_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc <= desc_next;
    end
  end

endmodule

// ----- hw/rtl/fpn_queue.sv -----
// Small descriptor queue between the front end and the divider.
// First-word-fall-through storage with a fill count. Depends on fpn_pkg.
module fpn_queue #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  fpn_pkg::desc_t             push_data,
  input  logic                       pop,
  output logic                       pop_valid,
  output fpn_pkg::desc_t             pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import fpn_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  desc_t            store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_pop;

  assign pop_valid = (count != '0);
  assign pop_data  = store[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/fpn_back.sv -----
// Back end of the pulse normalizer: pipelined restoring divider and result assembly.
// One quotient bit per stage, one new descriptor per cycle. Depends on fpn_pkg.
module fpn_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  fpn_pkg::desc_t           in_desc,
  output logic                     done,
  output logic [fpn_pkg::OUT_W-1:0] norm_value
);
  import fpn_pkg::*;

  localparam int NSTEP = QUOT_W;

  logic             vld   [NSTEP];
  op_t              op_q  [NSTEP];
  logic [SEG_W-1:0] seg_q [NSTEP];
  logic [PT_W-1:0]  den_q [NSTEP];
  logic [PT_W-1:0]  rem_q [NSTEP];
  logic [QUOT_W-1:0] quot_q [NSTEP];

  logic [PT_W:0]   part [NSTEP];
  logic [PT_W:0]   diff [NSTEP];
  logic [PT_W-1:0] den_in [NSTEP];
  logic            ge [NSTEP];
  logic [PT_W-1:0] rem_d [NSTEP];

  logic [OUT_W-1:0] base_value;
  logic [OUT_W-1:0] result;

  // Step zero compares the numerator itself and gives the integer bit; since the
  // numerator never exceeds the divisor, the remainder always fits back in 16 bits.
  always_comb begin
    for (int i = 0; i < NSTEP; i++) begin
      if (i == 0) begin
        part[i]   = {1'b0, in_desc.num};
        den_in[i] = in_desc.den;
      end else begin
        part[i]   = {rem_q[i-1], 1'b0};
        den_in[i] = den_q[i-1];
      end
      diff[i]  = part[i] - {1'b0, den_in[i]};
      ge[i]    = (part[i] >= {1'b0, den_in[i]});
      rem_d[i] = ge[i] ? diff[i][PT_W-1:0] : part[i][PT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTEP; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < NSTEP; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q[0]   <= in_desc.op;
    seg_q[0]  <= in_desc.seg;
    den_q[0]  <= in_desc.den;
    rem_q[0]  <= rem_d[0];
    quot_q[0] <= {{(QUOT_W-1){1'b0}}, ge[0]};
    for (int i = 1; i < NSTEP; i++) begin
      op_q[i]   <= op_q[i-1];
      seg_q[i]  <= seg_q[i-1];
      den_q[i]  <= den_q[i-1];
      rem_q[i]  <= rem_d[i];
      quot_q[i] <= {quot_q[i-1][QUOT_W-2:0], ge[i]};
    end
  end

  assign base_value = {{(OUT_W-SEG_W-FRAC_W){1'b0}}, seg_q[NSTEP-1], {FRAC_W{1'b0}}};

  always_comb begin
    unique case (op_q[NSTEP-1])
      OP_ZERO: result = '0;
      OP_FULL: result = NORM_FULL;
      OP_BASE: result = base_value;
      OP_DIV:  result = base_value + {{(OUT_W-QUOT_W){1'b0}}, quot_q[NSTEP-1]};
      default: result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[NSTEP-1];
    end
  end

  always_ff @(posedge clk) begin
    norm_value <= result;
  end

endmodule

// ----- hw/rtl/five_point_pulse_normalizer.sv -----
// Top level of the five-point pulse normalizer.
// Ties the front end, descriptor queue and divider back end together. Depends on fpn_pkg.
//
//   Channel   Signals                          Handshake
//   --------  -------------------------------  ------------------------------------------
//   input     start, busy, pulse_width         item taken at an edge with start && !busy
//   result    done, norm_value                 one-cycle strobe, taken at the ending edge
//   config    cfg_valid, cfg_ready,            write at an edge with cfg_valid && cfg_ready
//             cfg_index, cfg_data
//
// Throughput is one item per clock while busy is low. Between the accepting edge and done
// lie the classify register, the queue slot, the divider, which resolves one of its 15
// quotient bits per pipeline stage, and the output register.
// Reset (rst, synchronous, active high) loads the default setpoints 1000, 1250, 1500,
// 1750 and 2000 and empties the pipeline. The result side cannot stall, so the divider
// drains the queue every cycle; busy only rises if the queue nears full.
module five_point_pulse_normalizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [fpn_pkg::PT_W-1:0]      pulse_width,
  output logic                          done,
  output logic [fpn_pkg::OUT_W-1:0]     norm_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpn_pkg::PT_W-1:0]      cfg_data
);
  import fpn_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             accept;
  logic             front_valid;
  desc_t            front_desc;
  logic             queue_valid;
  desc_t            queue_desc;
  logic [CNT_W-1:0] queue_count;

  // Setpoint registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  // One slot is kept free for the descriptor sitting in the classify register.
  assign busy   = (queue_count >= CNT_W'(QUEUE_DEPTH - 1));
  assign accept = start && !busy;

  fpn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pulse_width (pulse_width),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .desc_valid  (front_valid),
    .desc        (front_desc)
  );

  fpn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_data (front_desc),
    .pop       (queue_valid),
    .pop_valid (queue_valid),
    .pop_data  (queue_desc),
    .count     (queue_count)
  );

  fpn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (queue_valid),
    .in_desc    (queue_desc),
    .done       (done),
    .norm_value (norm_value)
  );

  // The queue never overflows.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    queue_count <= CNT_W'(QUEUE_DEPTH))
    else $error("descriptor queue overflow");

  // An accepted item reaches the classify register on the next edge.
  a_front_capture: assert property (@(posedge clk) disable iff (rst)
    accept |=> front_valid)
    else $error("accepted item not captured by the front end");

  // Classification keeps the numerator within the divisor, so the quotient stays in range.
  a_div_operands: assert property (@(posedge clk) disable iff (rst)
    (queue_valid && queue_desc.op == OP_DIV) |-> (queue_desc.num <= queue_desc.den))
    else $error("segment numerator exceeds its length");

  // A result never exceeds full scale.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (norm_value <= NORM_FULL))
    else $error("normalized value above full scale");

endmodule
